FILE: rtl/php_pkg.sv
package php_pkg;

	localparam int MAX_NESTING_DEF = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_TYPE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECODE_TUNNELS = 2'd1;

	localparam logic [2:0] LINK_NULL    = 3'd0;
	localparam logic [2:0] LINK_PPP     = 3'd1;
	localparam logic [2:0] LINK_HDLC    = 3'd2;
	localparam logic [2:0] LINK_ETH     = 3'd3;
	localparam logic [2:0] LINK_COOKED  = 3'd4;
	localparam logic [2:0] LINK_RADIO   = 3'd5;
	localparam logic [2:0] LINK_RAW     = 3'd6;
	localparam logic [2:0] LINK_RESET   = LINK_ETH;

	localparam logic [2:0] ST_IPV4    = 3'd0;
	localparam logic [2:0] ST_IPV6    = 3'd1;
	localparam logic [2:0] ST_BAD_FCS = 3'd2;
	localparam logic [2:0] ST_FRAG    = 3'd3;
	localparam logic [2:0] ST_NOT_IP  = 3'd4;
	localparam logic [2:0] ST_TRUNC   = 3'd5;

	localparam logic [1:0] TUN_NONE = 2'd0;
	localparam logic [1:0] TUN_GTP  = 2'd1;
	localparam logic [1:0] TUN_TZSP = 2'd2;
	localparam logic [1:0] TUN_IPIP = 2'd3;

	localparam logic [15:0] KIND_DOT1Q       = 16'h8100;
	localparam logic [15:0] KIND_LABEL_UNI   = 16'h8847;
	localparam logic [15:0] KIND_LABEL_MULTI = 16'h8848;
	localparam logic [15:0] KIND_PPP_SESSION = 16'h8864;
	localparam logic [7:0]  LLC_SNAP_SAP     = 8'hAA;
	localparam logic [7:0]  RADIO_FCS_BAD    = 8'h50;
	localparam logic [15:0] UDP_PORT_GTPU    = 16'd2152;
	localparam logic [15:0] UDP_PORT_TZ      = 16'd37008;
	localparam logic [15:0] V4_FRAG_BITS     = 16'h3FFF;
	localparam logic [7:0]  V6_DEST_OPT      = 8'h3C;
	localparam logic [7:0]  GTP_MSG_TPDU     = 8'hFF;
	localparam logic [7:0]  NEXT_IP_IN_IP    = 8'd41;
	localparam logic [7:0]  NEXT_UDP         = 8'd17;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] l3_offset;
		logic [11:0] l3_header_len;
		logic [7:0]  l4_protocol;
		logic [11:0] vlan_id;
		logic        vlan_seen;
		logic        mpls_seen;
		logic        pppoe_seen;
		logic [1:0]  tunnel_kind;
		logic [15:0] l3_size;
	} php_verdict_t;

endpackage

FILE: rtl/php_in_if.sv
interface php_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  pkt_byte;
	logic        last_byte;
	logic [15:0] wire_len;

	modport source(output valid, pkt_byte, last_byte, wire_len, input ready);
	modport sink(input valid, pkt_byte, last_byte, wire_len, output ready);
endinterface

FILE: rtl/php_out_if.sv
interface php_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] l3_offset;
	logic [11:0] l3_header_len;
	logic [7:0]  l4_protocol;
	logic [11:0] vlan_id;
	logic        vlan_seen;
	logic        mpls_seen;
	logic        pppoe_seen;
	logic [1:0]  tunnel_kind;
	logic [15:0] l3_size;

	modport source(output valid, status, l3_offset, l3_header_len, l4_protocol, vlan_id,
		vlan_seen, mpls_seen, pppoe_seen, tunnel_kind, l3_size, input ready);
	modport sink(input valid, status, l3_offset, l3_header_len, l4_protocol, vlan_id,
		vlan_seen, mpls_seen, pppoe_seen, tunnel_kind, l3_size, output ready);
endinterface

FILE: rtl/php_walker.sv
module php_walker #(
	parameter int MAX_NESTING = php_pkg::MAX_NESTING_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic [7:0]           pkt_byte,
	input  logic                 last_byte,
	input  logic [15:0]          wire_len,
	input  logic [2:0]           link_type,
	input  logic                 decode_tunnels,
	output logic                 verdict_load,
	output php_pkg::php_verdict_t verdict
);

	localparam int NW = $clog2(MAX_NESTING + 1);

	typedef enum logic [20:0] {
		PH_START    = 21'd1 << 0,
		PH_DONE     = 21'd1 << 1,
		PH_TYPE     = 21'd1 << 2,
		PH_ETH      = 21'd1 << 3,
		PH_ETH_DSAP = 21'd1 << 4,
		PH_RT_LEN   = 21'd1 << 5,
		PH_RT_FLAGS = 21'd1 << 6,
		PH_FC       = 21'd1 << 7,
		PH_LLC_DSAP = 21'd1 << 8,
		PH_VLAN     = 21'd1 << 9,
		PH_MPLS     = 21'd1 << 10,
		PH_IP_VER   = 21'd1 << 11,
		PH_V4_FRAG  = 21'd1 << 12,
		PH_V4_NEXT  = 21'd1 << 13,
		PH_V6_NEXT  = 21'd1 << 14,
		PH_V6_OPT   = 21'd1 << 15,
		PH_UDP      = 21'd1 << 16,
		PH_GTP      = 21'd1 << 17,
		PH_TZ_HDR   = 21'd1 << 18,
		PH_TZ_TAG   = 21'd1 << 19,
		PH_TZ_LEN   = 21'd1 << 20
	} phase_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] l3_off;
		logic [11:0] hdr_len;
		logic [7:0]  l4;
		logic [11:0] vid;
		logic        vseen;
		logic        mseen;
		logic        pseen;
		logic [1:0]  tunnel;
	} res_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] nfp;
		logic [2:0]  gather;
		logic [31:0] scr;
		logic [15:0] ek;
		logic [31:0] base;
		logic [31:0] pend;
		logic [31:0] ip;
		logic [31:0] udp;
		logic        only4;
		logic [NW-1:0] nest;
		res_t        res;
	} walk_t;

	function automatic walk_t want_f(walk_t st, phase_t ph, logic [31:0] pos, logic [2:0] n);
		walk_t r;
		r = st;
		r.phase = ph;
		r.nfp = pos;
		r.gather = n;
		r.scr = '0;
		return r;
	endfunction

	function automatic walk_t finish_f(walk_t st, logic [2:0] code);
		walk_t r;
		r = st;
		r.res.status = code;
		r.phase = PH_DONE;
		return r;
	endfunction

	function automatic walk_t ip_f(walk_t st, logic [31:0] at, logic v4only);
		walk_t r;
		r = st;
		r.ip = at;
		r.only4 = v4only;
		return want_f(r, PH_IP_VER, at, 3'd1);
	endfunction

	function automatic walk_t tags_f(walk_t st, logic [31:0] at);
		walk_t r;
		r = st;
		if (r.ek == php_pkg::KIND_DOT1Q) begin
			r.pend = at;
			r = want_f(r, PH_VLAN, at, 3'd2);
		end else if (r.ek == php_pkg::KIND_LABEL_UNI || r.ek == php_pkg::KIND_LABEL_MULTI) begin
			r.res.mseen = 1'b1;
			r.pend = at;
			r = want_f(r, PH_MPLS, at + 32'd2, 3'd1);
		end else if (r.ek == php_pkg::KIND_PPP_SESSION) begin
			r.res.pseen = 1'b1;
			r = ip_f(r, at + 32'd8, 1'b0);
		end else begin
			r = ip_f(r, at, 1'b0);
		end
		return r;
	endfunction

	function automatic walk_t ipv_f(walk_t st, logic [2:0] code, logic dt);
		walk_t r;
		r = st;
		r.res.status = code;
		r.res.l3_off = r.ip;
		if (dt && r.res.l4 == php_pkg::NEXT_UDP && r.nest < NW'(MAX_NESTING)) begin
			r.udp = r.ip + 32'(r.res.hdr_len);
			r = want_f(r, PH_UDP, r.udp, 3'd4);
		end else begin
			r = finish_f(r, code);
		end
		return r;
	endfunction

	walk_t       st_q, s, n;
	logic [31:0] byte_pos_q;
	logic [31:0] v;
	logic [31:0] w;
	logic [15:0] v16;
	logic [7:0]  g8;
	logic [2:0]  vst;
	logic        fire;

	always_comb begin
		s = st_q;
		if (st_q.phase == PH_START) begin
			s = '0;
			s.phase = PH_DONE;
			case (link_type)
				php_pkg::LINK_NULL: s = ip_f(s, 32'd4, 1'b0);
				php_pkg::LINK_PPP, php_pkg::LINK_HDLC: begin
					s.pend = 32'd4;
					s = want_f(s, PH_TYPE, 32'd2, 3'd2);
				end
				php_pkg::LINK_ETH: s = want_f(s, PH_ETH, 32'd12, 3'd2);
				php_pkg::LINK_COOKED: begin
					s.pend = 32'd16;
					s = want_f(s, PH_TYPE, 32'd14, 3'd2);
				end
				php_pkg::LINK_RADIO: s = want_f(s, PH_RT_LEN, 32'd2, 3'd2);
				php_pkg::LINK_RAW: s = ip_f(s, 32'd0, 1'b0);
				default: s = finish_f(s, php_pkg::ST_TRUNC);
			endcase
		end

		n = s;
		v = '0;
		w = '0;
		v16 = '0;
		g8 = '0;
		fire = s.phase != PH_DONE && s.nfp == byte_pos_q;
		if (fire) begin
			n.scr = {s.scr[23:0], pkt_byte};
			v = n.scr;
			v16 = v[15:0];
			if (s.gather > 3'd1) begin
				n.gather = s.gather - 3'd1;
				n.nfp = s.nfp + 32'd1;
			end else begin
				case (s.phase)
					PH_TYPE: begin
						n.ek = v16;
						n = tags_f(n, n.pend);
					end
					PH_ETH: begin
						if (v16 >= 16'd1536) begin
							n.ek = v16;
							n = tags_f(n, n.base + 32'd14);
						end else if (v16 >= 16'd1 && v16 <= 16'd1500) begin
							n = want_f(n, PH_ETH_DSAP, n.base + 32'd14, 3'd1);
						end else begin
							n.ek = '0;
							n = tags_f(n, n.base + 32'd14);
						end
					end
					PH_ETH_DSAP: begin
						if (v == 32'(php_pkg::LLC_SNAP_SAP)) begin
							n.pend = n.base + 32'd22;
							n = want_f(n, PH_TYPE, n.base + 32'd20, 3'd2);
						end else begin
							n.ek = '0;
							n = tags_f(n, n.base + 32'd14);
						end
					end
					PH_RT_LEN: begin
						n.base = {16'd0, v[7:0], v[15:8]};
						if (n.base < 32'd4) n = finish_f(n, php_pkg::ST_NOT_IP);
						else if (n.base > 32'd16) n = want_f(n, PH_RT_FLAGS, 32'd16, 3'd1);
						else n = want_f(n, PH_FC, n.base, 3'd2);
					end
					PH_RT_FLAGS: begin
						if ((v[7:0] & php_pkg::RADIO_FCS_BAD) == php_pkg::RADIO_FCS_BAD)
							n = finish_f(n, php_pkg::ST_BAD_FCS);
						else
							n = want_f(n, PH_FC, n.base, 3'd2);
					end
					PH_FC: begin
						if (v[11:10] != 2'd2) begin
							n = finish_f(n, php_pkg::ST_NOT_IP);
						end else begin
							w = (v[1:0] == 2'd1 || v[1:0] == 2'd2) ? 32'd26 : 32'd24;
							n.pend = n.base + w + 32'd8;
							n = want_f(n, PH_LLC_DSAP, n.base + w, 3'd1);
						end
					end
					PH_LLC_DSAP: begin
						if (v == 32'(php_pkg::LLC_SNAP_SAP)) begin
							n = want_f(n, PH_TYPE, n.pend - 32'd2, 3'd2);
						end else begin
							n.ek = '0;
							n = tags_f(n, n.pend);
						end
					end
					PH_VLAN: begin
						n.res.vid = v[11:0];
						n.res.vseen = 1'b1;
						n = ip_f(n, n.pend + 32'd4, 1'b0);
					end
					PH_MPLS: begin
						n.pend = n.pend + 32'd4;
						if (v[0]) n = ip_f(n, n.pend, 1'b0);
						else n = want_f(n, PH_MPLS, n.pend + 32'd2, 3'd1);
					end
					PH_IP_VER: begin
						if (v[7:4] == 4'd4) begin
							n.res.hdr_len = {6'd0, v[3:0], 2'b00};
							if (v[3:0] < 4'd5) n = finish_f(n, php_pkg::ST_NOT_IP);
							else n = want_f(n, PH_V4_FRAG, n.ip + 32'd6, 3'd2);
						end else if (v[7:4] == 4'd6 && !n.only4) begin
							n = want_f(n, PH_V6_NEXT, n.ip + 32'd6, 3'd1);
						end else begin
							n = finish_f(n, php_pkg::ST_NOT_IP);
						end
					end
					PH_V4_FRAG: begin
						n.pend = {16'd0, v16};
						n = want_f(n, PH_V4_NEXT, n.ip + 32'd9, 3'd1);
					end
					PH_V4_NEXT: begin
						n.res.l4 = v[7:0];
						if (v[7:0] == php_pkg::NEXT_IP_IN_IP && n.nest < NW'(MAX_NESTING)) begin
							n.nest = n.nest + NW'(1);
							n.res.tunnel = php_pkg::TUN_IPIP;
							n = ip_f(n, n.ip + 32'(n.res.hdr_len), 1'b0);
						end else if ((n.pend[15:0] & php_pkg::V4_FRAG_BITS) != 16'd0) begin
							n.res.l3_off = n.ip;
							n = finish_f(n, php_pkg::ST_FRAG);
						end else begin
							n = ipv_f(n, php_pkg::ST_IPV4, decode_tunnels);
						end
					end
					PH_V6_NEXT: begin
						n.res.l4 = v[7:0];
						if (v[7:0] == php_pkg::V6_DEST_OPT) begin
							n = want_f(n, PH_V6_OPT, n.ip + 32'd40, 3'd2);
						end else begin
							n.res.hdr_len = 12'd40;
							n = ipv_f(n, php_pkg::ST_IPV6, decode_tunnels);
						end
					end
					PH_V6_OPT: begin
						n.res.l4 = v[15:8];
						n.res.hdr_len = 12'd48 + {1'b0, v[7:0], 3'b000};
						n = ipv_f(n, php_pkg::ST_IPV6, decode_tunnels);
					end
					PH_UDP: begin
						if (v[31:16] == php_pkg::UDP_PORT_GTPU || v16 == php_pkg::UDP_PORT_GTPU)
							n = want_f(n, PH_GTP, n.udp + 32'd8, 3'd2);
						else if (v[31:16] == php_pkg::UDP_PORT_TZ || v16 == php_pkg::UDP_PORT_TZ)
							n = want_f(n, PH_TZ_HDR, n.udp + 32'd8, 3'd4);
						else
							n = finish_f(n, n.res.status);
					end
					PH_GTP: begin
						g8 = v[15:8];
						if (g8[7:5] == 3'd1 && v[7:0] == php_pkg::GTP_MSG_TPDU) begin
							n.nest = n.nest + NW'(1);
							n.res.tunnel = php_pkg::TUN_GTP;
							n = ip_f(n, n.udp + ((g8[2:0] != 3'd0) ? 32'd20 : 32'd16), 1'b1);
						end else begin
							n = finish_f(n, n.res.status);
						end
					end
					PH_TZ_HDR: begin
						if (v[31:24] == 8'd1 && v[23:16] == 8'd0 && v16 == 16'd1)
							n = want_f(n, PH_TZ_TAG, n.udp + 32'd12, 3'd1);
						else
							n = finish_f(n, n.res.status);
					end
					PH_TZ_TAG: begin
						if (v == 32'd0) begin
							n = want_f(n, PH_TZ_TAG, byte_pos_q + 32'd1, 3'd1);
						end else if (v == 32'd1) begin
							n.nest = n.nest + NW'(1);
							n.res.tunnel = php_pkg::TUN_TZSP;
							n.ek = '0;
							n.base = byte_pos_q + 32'd1;
							n = want_f(n, PH_ETH, byte_pos_q + 32'd13, 3'd2);
						end else begin
							n = want_f(n, PH_TZ_LEN, byte_pos_q + 32'd1, 3'd1);
						end
					end
					PH_TZ_LEN: n = want_f(n, PH_TZ_TAG, byte_pos_q + 32'd1 + v, 3'd1);
					default: n = finish_f(n, php_pkg::ST_TRUNC);
				endcase
			end
		end
	end

	// verdict from the state after this byte
	always_comb begin
		vst = (n.phase == PH_DONE) ? n.res.status : php_pkg::ST_TRUNC;
		verdict = '0;
		verdict.status = vst;
		if (vst != php_pkg::ST_BAD_FCS && vst != php_pkg::ST_NOT_IP
				&& vst != php_pkg::ST_TRUNC) begin
			verdict.l3_offset = n.res.l3_off[15:0];
			verdict.l3_header_len = n.res.hdr_len;
			verdict.l4_protocol = n.res.l4;
			verdict.vlan_id = n.res.vid;
			verdict.vlan_seen = n.res.vseen;
			verdict.mpls_seen = n.res.mseen;
			verdict.pppoe_seen = n.res.pseen;
			verdict.tunnel_kind = n.res.tunnel;
			verdict.l3_size = ({16'd0, wire_len} > n.res.l3_off)
				? wire_len - n.res.l3_off[15:0] : 16'd0;
		end
	end

	assign verdict_load = in_fire && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			st_q.phase <= PH_START;
			byte_pos_q <= '0;
		end else if (in_fire) begin
			if (last_byte) begin
				// restart for the next packet
				st_q <= n;
				st_q.phase <= PH_START;
				st_q.nfp <= '0;
				byte_pos_q <= '0;
			end else begin
				st_q <= n;
				if (byte_pos_q != 32'hFFFF_FFFF) byte_pos_q <= byte_pos_q + 32'd1;
			end
		end
	end

endmodule

FILE: rtl/php_out_reg.sv
module php_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  php_pkg::php_verdict_t din,
	output logic                  can_load,
	php_out_if.source             res_out
);

	php_pkg::php_verdict_t data_q;
	logic                  valid_q;

	assign can_load = !valid_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) data_q <= din;
	end

	assign res_out.valid         = valid_q;
	assign res_out.status        = data_q.status;
	assign res_out.l3_offset     = data_q.l3_offset;
	assign res_out.l3_header_len = data_q.l3_header_len;
	assign res_out.l4_protocol   = data_q.l4_protocol;
	assign res_out.vlan_id       = data_q.vlan_id;
	assign res_out.vlan_seen     = data_q.vlan_seen;
	assign res_out.mpls_seen     = data_q.mpls_seen;
	assign res_out.pppoe_seen    = data_q.pppoe_seen;
	assign res_out.tunnel_kind   = data_q.tunnel_kind;
	assign res_out.l3_size       = data_q.l3_size;

endmodule

FILE: rtl/packet_header_parser_core.sv
// The verdict is registered and valid in the cycle after the last byte of a packet is accepted.
// Throughput: one packet byte per cycle while the result register is free or being read;
// the parse state and the field walk advance by one small step per byte.
// Reset (arst_n low): link type Ethernet, tunnel decoding off, parser at packet start,
// no verdict pending.
module packet_header_parser_core #(
	parameter int MAX_NESTING = php_pkg::MAX_NESTING_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [php_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [php_pkg::CFG_DATA_W-1:0]  cfg_data,
	php_in_if.sink                          pkt_in,
	php_out_if.source                       res_out
);

	logic [2:0]            link_type_q;
	logic                  decode_tunnels_q;
	logic                  in_fire;
	logic                  can_load;
	logic                  verdict_load;
	php_pkg::php_verdict_t verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_type_q <= php_pkg::LINK_RESET;
			decode_tunnels_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				php_pkg::CFG_LINK_TYPE: link_type_q <= cfg_data[2:0];
				php_pkg::CFG_DECODE_TUNNELS: decode_tunnels_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign pkt_in.ready = can_load;
	assign in_fire = pkt_in.valid && can_load;

	php_walker #(.MAX_NESTING(MAX_NESTING)) u_walker (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.pkt_byte(pkt_in.pkt_byte),
		.last_byte(pkt_in.last_byte),
		.wire_len(pkt_in.wire_len),
		.link_type(link_type_q),
		.decode_tunnels(decode_tunnels_q),
		.verdict_load(verdict_load),
		.verdict(verdict)
	);

	php_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.load(verdict_load),
		.din(verdict),
		.can_load(can_load),
		.res_out(res_out)
	);

	a_rise_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_out.valid) |-> $past(pkt_in.valid && pkt_in.ready && pkt_in.last_byte))
		else $error("verdict appeared without a last byte transaction");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pkt_in.ready |-> (res_out.valid && !res_out.ready))
		else $error("input stalled while result register free");

	a_discard_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && (res_out.status == php_pkg::ST_NOT_IP
			|| res_out.status == php_pkg::ST_TRUNC || res_out.status == php_pkg::ST_BAD_FCS))
		|-> (res_out.l3_offset == 16'd0 && res_out.l3_size == 16'd0))
		else $error("discard verdict carries header fields");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> (res_out.status <= php_pkg::ST_TRUNC))
		else $error("status code out of range");

endmodule
